>>> hdl/assert_macros.svh
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Condition must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("assertion failed: cond");
// Antecedent implies consequent in the same cycle.
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: ante -> cons");
`else
`define ASSERT_ALWAYS(lbl, clk, rst, cond)
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons)
`endif
`endif

>>> hdl/hdtw_pkg.sv
// Package: sequence codes, lengths and the hex to segment table.
`default_nettype none
package hdtw_pkg;

  localparam logic [1:0] KIND_IDLE  = 2'd0;
  localparam logic [1:0] KIND_INIT  = 2'd1;
  localparam logic [1:0] KIND_FRAME = 2'd2;

  localparam logic [5:0] INIT_LEN  = 6'd23;
  localparam logic [5:0] FRAME_LEN = 6'd48;

  localparam logic [7:0] ADDR_CMD    = 8'h40;
  localparam logic [7:0] ADDR_DIGIT0 = 8'hc0;
  localparam logic [4:0] CTRL_BASE   = 5'b10001;  // 0x88 with low 3 bits free

  function automatic logic [7:0] seg_code(input logic [3:0] nib);
    logic [7:0] s;
    case (nib)
      4'h0: s = 8'h3f;
      4'h1: s = 8'h06;
      4'h2: s = 8'h5b;
      4'h3: s = 8'h4f;
      4'h4: s = 8'h66;
      4'h5: s = 8'h6d;
      4'h6: s = 8'h7d;
      4'h7: s = 8'h07;
      4'h8: s = 8'h7f;
      4'h9: s = 8'h6f;
      4'ha: s = 8'h77;
      4'hb: s = 8'h7c;
      4'hc: s = 8'h39;
      4'hd: s = 8'h5e;
      4'he: s = 8'h79;
      4'hf: s = 8'h71;
      default: s = 8'h00;
    endcase
    return s;
  endfunction

endpackage
`default_nettype wire

>>> hdl/hex_display_two_wire_driver_top.sv
// Top level: two-wire seven-segment display driver, one request per clock while out_ready holds high.
//
//  channel | signals                          | handshake
//  --------+----------------------------------+-------------------------
//  in      | req_type, hex_value              | in_valid / in_ready
//  out     | bus_clock, bus_data, busy_res    | out_valid / out_ready
//  cfg     | cfg_wdata (brightness)           | cfg_we, no wait
//
// For each request, the whole bit-level sequencer update is
// one step of logic from the state registers into the result register.
// in_ready is high whenever the result register is empty or being drained,
// so a request is taken every cycle while out_ready holds high.
// rst (synchronous) loads the power-up state: init sequence pending,
// data line high, brightness 1. Output stalls hold the result register.
`default_nettype none
`include "assert_macros.svh"
module hex_display_two_wire_driver_top (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_wdata,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        req_type,
  input  wire logic [11:0] hex_value,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             bus_clock,
  output logic             bus_data,
  output logic             busy_res
);
  import hdtw_pkg::*;

  // symbol classes of one bit period
  localparam logic [1:0] SYM_START = 2'd0;
  localparam logic [1:0] SYM_STOP  = 2'd1;
  localparam logic [1:0] SYM_BIT   = 2'd2;
  localparam logic [1:0] SYM_IDLE  = 2'd3;

  // state
  logic [2:0]  brightness;
  logic [1:0]  tick_phase, tick_phase_next;
  logic [5:0]  symbol_count, symbol_count_next;
  logic [1:0]  sequence_kind, sequence_kind_next;
  logic        data_level, data_level_next;
  logic [23:0] frame_segments, frame_segments_next;
  logic [23:0] waiting_segments, waiting_segments_next;
  logic        waiting_flag, waiting_flag_next;

  // decode
  logic        busy;
  logic [1:0]  sym;
  logic        bitv;
  logic [7:0]  cur_byte;
  logic [3:0]  bit_pos;
  logic [5:0]  sidx;       // symbol index minus one
  logic [2:0]  byte_sel;
  logic [23:0] new_segs;
  logic [5:0]  count_inc;
  logic [5:0]  seq_len;
  logic        res_clock, res_data, res_busy;
  logic        in_fire;

  assign in_ready = !out_valid || out_ready;
  assign in_fire  = in_valid && in_ready;
  assign busy     = (sequence_kind == KIND_INIT) || (sequence_kind == KIND_FRAME);
  assign sidx     = symbol_count - 6'd1;

  assign new_segs = {seg_code(hex_value[3:0]), seg_code(hex_value[7:4]),
                     seg_code(hex_value[11:8])};

  // which byte of the frame and which bit within its nine-slot group
  always_comb begin
    if (sidx >= 6'd36) begin
      byte_sel = 3'd4;
      bit_pos  = 4'(sidx - 6'd36);
    end else if (sidx >= 6'd27) begin
      byte_sel = 3'd3;
      bit_pos  = 4'(sidx - 6'd27);
    end else if (sidx >= 6'd18) begin
      byte_sel = 3'd2;
      bit_pos  = 4'(sidx - 6'd18);
    end else if (sidx >= 6'd9) begin
      byte_sel = 3'd1;
      bit_pos  = 4'(sidx - 6'd9);
    end else begin
      byte_sel = 3'd0;
      bit_pos  = 4'(sidx);
    end
  end

  // symbol decode for the current position
  always_comb begin
    sym      = SYM_IDLE;
    cur_byte = 8'h00;
    bitv     = 1'b0;
    if (sequence_kind == KIND_INIT) begin
      if (symbol_count == 6'd0 || symbol_count == 6'd11) begin
        sym = SYM_START;
      end else if (symbol_count == 6'd10 || symbol_count == 6'd21) begin
        sym = SYM_STOP;
      end else if (symbol_count >= 6'd1 && symbol_count <= 6'd9) begin
        sym      = SYM_BIT;
        cur_byte = ADDR_CMD;
        if (symbol_count <= 6'd8) begin
          bitv = cur_byte[3'(symbol_count - 6'd1)];
        end
      end else if (symbol_count >= 6'd12 && symbol_count <= 6'd20) begin
        sym      = SYM_BIT;
        cur_byte = {CTRL_BASE, brightness};
        if (symbol_count <= 6'd19) begin
          bitv = cur_byte[3'(symbol_count - 6'd12)];
        end
      end
    end else if (sequence_kind == KIND_FRAME) begin
      if (symbol_count == 6'd0) begin
        sym = SYM_START;
      end else if (symbol_count == 6'd46) begin
        sym = SYM_STOP;
      end else if (symbol_count <= 6'd45) begin
        sym = SYM_BIT;
        case (byte_sel)
          3'd0:    cur_byte = ADDR_DIGIT0;
          3'd1:    cur_byte = frame_segments[7:0];
          3'd2:    cur_byte = frame_segments[15:8];
          3'd3:    cur_byte = frame_segments[23:16];
          default: cur_byte = 8'h00;
        endcase
        // ninth slot is the acknowledge: data held low
        if (!bit_pos[3]) begin
          bitv = cur_byte[bit_pos[2:0]];
        end
      end
    end
  end

  assign count_inc = symbol_count + 6'd1;
  assign seq_len   = (sequence_kind == KIND_INIT) ? INIT_LEN : FRAME_LEN;

  // next state and result for the request at the input
  always_comb begin
    tick_phase_next       = tick_phase;
    symbol_count_next     = symbol_count;
    sequence_kind_next    = sequence_kind;
    data_level_next       = data_level;
    frame_segments_next   = frame_segments;
    waiting_segments_next = waiting_segments;
    waiting_flag_next     = waiting_flag;
    res_clock             = 1'b1;
    res_data              = data_level;
    res_busy              = 1'b0;
    if (req_type) begin
      // new value: queue it behind a running sequence, or start at once
      if (busy) begin
        waiting_segments_next = new_segs;
        waiting_flag_next     = 1'b1;
        res_clock             = tick_phase[1];
      end else begin
        frame_segments_next = new_segs;
        sequence_kind_next  = KIND_FRAME;
        symbol_count_next   = 6'd0;
        tick_phase_next     = 2'd0;
        res_clock           = 1'b0;
      end
      res_busy = 1'b1;
    end else if (busy) begin
      if (sym == SYM_BIT && tick_phase == 2'd1) begin
        data_level_next = bitv;
      end else if (sym == SYM_START && tick_phase == 2'd3) begin
        data_level_next = 1'b0;
      end else if (sym == SYM_STOP && tick_phase == 2'd3) begin
        data_level_next = 1'b1;
      end
      res_clock = tick_phase[1];
      res_data  = data_level_next;
      res_busy  = 1'b1;
      if (tick_phase == 2'd3) begin
        tick_phase_next   = 2'd0;
        symbol_count_next = count_inc;
        if (count_inc >= seq_len) begin
          if (waiting_flag) begin
            // queued value follows without a halt
            waiting_flag_next   = 1'b0;
            frame_segments_next = waiting_segments;
            sequence_kind_next  = KIND_FRAME;
            symbol_count_next   = 6'd0;
          end else begin
            sequence_kind_next = KIND_IDLE;
            symbol_count_next  = 6'd0;
          end
        end
      end else begin
        tick_phase_next = tick_phase + 2'd1;
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      brightness    <= 3'd1;
      tick_phase    <= 2'd0;
      symbol_count  <= 6'd0;
      sequence_kind <= KIND_INIT;
      data_level    <= 1'b1;
      waiting_flag  <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_we) begin
        brightness <= cfg_wdata;
      end
      if (in_fire) begin
        tick_phase    <= tick_phase_next;
        symbol_count  <= symbol_count_next;
        sequence_kind <= sequence_kind_next;
        data_level    <= data_level_next;
        waiting_flag  <= waiting_flag_next;
      end
      out_valid <= in_fire || (out_valid && !out_ready);
    end
  end

  // segment holding registers; model reset clears them
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_segments   <= 24'd0;
      waiting_segments <= 24'd0;
    end else if (in_fire) begin
      frame_segments   <= frame_segments_next;
      waiting_segments <= waiting_segments_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (in_fire) begin
      bus_clock <= res_clock;
      bus_data  <= res_data;
      busy_res  <= res_busy;
    end
  end

  // a queued value only exists behind a running sequence
  `ASSERT_IMPLIES(a_wait_busy, clk, rst, waiting_flag, busy)
  // position never runs past the longest sequence
  `ASSERT_ALWAYS(a_count_range, clk, rst, symbol_count < FRAME_LEN)
  `ASSERT_IMPLIES(a_init_range, clk, rst, sequence_kind == KIND_INIT, symbol_count < INIT_LEN)
  // the clock is only ever driven low while a sequence runs
  `ASSERT_IMPLIES(a_clock_low_busy, clk, rst, out_valid && !bus_clock, busy_res)

endmodule
`default_nettype wire
